FILE: rtl/msx_pkg.sv
// Package: shared types, constants and the control program of the xorshift1024* block.
`default_nettype none
package msx_pkg;

   localparam int DEF_STREAMS  = 8;
   localparam int STREAM_W     = 3;
   localparam int SEED_W       = 32;
   localparam int WORD_W       = 64;
   localparam int HALF_W       = 32;
   localparam int POS_W        = 4;
   localparam int K_W          = 5;
   localparam int PC_W         = 4;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 64;
   localparam int STREAM_EXT_W = 7;

   localparam logic [HALF_W-1:0] WARM_MULT   = 32'd1812433253;
   localparam logic [WORD_W-1:0] OUT_MULT    = 64'd1181783497276652981;
   localparam logic [POS_W-1:0]  LAST_POS    = 4'd15;
   localparam logic [K_W-1:0]    FIRST_K     = 5'd1;
   localparam logic [K_W-1:0]    SEED_LAST_K = 5'd31;
   localparam logic              MODE_DRAW   = 1'b0;
   localparam logic              MODE_SEED   = 1'b1;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_IDLE,
      ACT_SEED_MUL,
      ACT_SEED_ADD,
      ACT_SEED_POS,
      ACT_RD_POS,
      ACT_RD_W0,
      ACT_RD_W1,
      ACT_MIX,
      ACT_MUL_LL,
      ACT_MUL_HL,
      ACT_MUL_LH,
      ACT_EMIT
   } act_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_DISPATCH,
      COND_LOOP_K,
      COND_WAIT_OUT
   } cond_type;

   typedef struct packed {
      act_type          act;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctl_type;

   typedef struct packed {
      logic accept;
      logic seed;
      logic in_range;
      logic k_last;
      logic out_free;
   } status_type;

   localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
   localparam logic [PC_W-1:0] PC_SEED_MUL  = 4'd1;
   localparam logic [PC_W-1:0] PC_DRAW      = 4'd5;

   function automatic ctl_type msx_rom(input logic [PC_W-1:0] pc);
      ctl_type w;
      unique case (pc)
         4'd0:    w = '{ACT_IDLE,     COND_DISPATCH, PC_DRAW};
         4'd1:    w = '{ACT_SEED_MUL, COND_NEXT,     PC_IDLE};
         4'd2:    w = '{ACT_SEED_ADD, COND_LOOP_K,   PC_SEED_MUL};
         4'd3:    w = '{ACT_SEED_POS, COND_JUMP,     PC_IDLE};
         4'd5:    w = '{ACT_RD_POS,   COND_NEXT,     PC_IDLE};
         4'd6:    w = '{ACT_RD_W0,    COND_NEXT,     PC_IDLE};
         4'd7:    w = '{ACT_RD_W1,    COND_NEXT,     PC_IDLE};
         4'd8:    w = '{ACT_MIX,      COND_NEXT,     PC_IDLE};
         4'd9:    w = '{ACT_MUL_LL,   COND_NEXT,     PC_IDLE};
         4'd10:   w = '{ACT_MUL_HL,   COND_NEXT,     PC_IDLE};
         4'd11:   w = '{ACT_MUL_LH,   COND_NEXT,     PC_IDLE};
         4'd12:   w = '{ACT_EMIT,     COND_WAIT_OUT, PC_IDLE};
         default: w = '{ACT_NOP,      COND_JUMP,     PC_IDLE};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/multi_stream_xorshift1024_star_top.sv
// Top level: multi-stream xorshift1024* generator with shared multiplier datapath.
// Each request word either seeds or draws one stream; an item is taken only while
// the sequencer sits at its idle step. A draw runs these steps back to idle, the result
// step holding while the output register is full: position read, two word reads
// from the word memory through its one read port, mix and write-back, three 32x32
// partial products on the one shared multiplier for the 64-bit output multiply, the
// result step and the idle step. Its result sits in an output register so the next
// item is taken while it waits. A seed runs 31 recurrence steps, each a multiply and
// an add step through the same multiplier, then a position write and the idle step.
// Items for a stream at or beyond STREAMS are dropped without a result. Drawing a
// stream before it has been seeded returns an unspecified word.
`default_nettype none
module multi_stream_xorshift1024_star_top
   import msx_pkg::*;
#(
   parameter int STREAMS = DEF_STREAMS
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [2:0] stream, [34:3] seed_value
   input  wire logic                  req_tuser,  // [0] mode
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata   // [63:0] random_word
);

   localparam int SIDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
   localparam int AW     = SIDX_W + POS_W;
   localparam int DEPTH  = STREAMS * 16;
   localparam logic [STREAM_EXT_W-1:0] STREAMS_LIM = STREAM_EXT_W'(STREAMS);

   ctl_type    ctl;
   status_type status;

   logic [STREAM_W-1:0] req_stream;
   logic [SEED_W-1:0]   req_seed;
   logic                req_accept;
   logic                in_range;
   logic                out_free;

   logic [STREAM_W-1:0] stream_ff;
   logic [HALF_W-1:0]   x_ff;
   logic [HALF_W-1:0]   lo_ff;
   logic [K_W-1:0]      k_ff;
   logic [POS_W-1:0]    p_ff;
   logic [WORD_W-1:0]   s0_ff;
   logic [WORD_W-1:0]   new_ff;
   logic [WORD_W-1:0]   prod_ff;
   logic [WORD_W-1:0]   acc_ff;
   logic [WORD_W-1:0]   word_q_ff;
   logic [POS_W-1:0]    pos_q_ff;
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_data_ff;

   logic [WORD_W-1:0]   words_mem [DEPTH];
   logic [POS_W-1:0]    pos_mem   [STREAMS];

   logic [STREAM_EXT_W-1:0] stream_ext;
   logic [SIDX_W-1:0]       sidx;
   logic [HALF_W-1:0]       mul_a;
   logic [HALF_W-1:0]       mul_b;
   logic                    mul_en;
   logic [HALF_W-1:0]       warm_x;
   logic [HALF_W-1:0]       seed_next;
   logic [WORD_W-1:0]       s1_a;
   logic [WORD_W-1:0]       s1_b;
   logic [WORD_W-1:0]       mix_word;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   logic [WORD_W-1:0]       wr_data;
   logic                    wr_en;
   logic                    pos_wr_en;
   logic [POS_W-1:0]        pos_wr_data;
   logic                    emit;

   assign req_stream = req_tdata[STREAM_W-1:0];
   assign req_seed   = req_tdata[STREAM_W+SEED_W-1:STREAM_W];
   assign req_tready = (ctl.act == ACT_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = ({(STREAM_EXT_W-STREAM_W)'(0), req_stream} < STREAMS_LIM);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = (ctl.act == ACT_EMIT) && out_free;

   assign status = '{
      accept:   req_accept,
      seed:     (req_tuser == MODE_SEED),
      in_range: in_range,
      k_last:   (k_ff == SEED_LAST_K),
      out_free: out_free
   };

   msx_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   assign stream_ext = {(STREAM_EXT_W-STREAM_W)'(0), stream_ff};
   assign sidx       = stream_ext[SIDX_W-1:0];

   assign warm_x    = x_ff ^ (x_ff >> 30);
   assign seed_next = prod_ff[HALF_W-1:0] + {(HALF_W-K_W)'(0), k_ff};
   assign s1_a      = word_q_ff ^ (word_q_ff << 31);
   assign s1_b      = s1_a ^ (s1_a >> 11);
   assign mix_word  = s0_ff ^ s1_b;

   // Pick multiplier operands and memory ports for the current step.
   always_comb begin
      mul_a       = new_ff[HALF_W-1:0];
      mul_b       = OUT_MULT[HALF_W-1:0];
      mul_en      = 1'b0;
      rd_addr     = {sidx, p_ff};
      wr_addr     = {sidx, p_ff};
      wr_data     = mix_word;
      wr_en       = 1'b0;
      pos_wr_en   = 1'b0;
      pos_wr_data = p_ff;
      case (ctl.act)
         ACT_SEED_MUL: begin
            mul_a  = warm_x;
            mul_b  = WARM_MULT;
            mul_en = 1'b1;
         end
         ACT_SEED_ADD: begin
            wr_addr = {sidx, k_ff[K_W-1:1]};
            wr_data = {seed_next, lo_ff};
            wr_en   = k_ff[0];
         end
         ACT_SEED_POS: begin
            pos_wr_en   = 1'b1;
            pos_wr_data = LAST_POS;
         end
         ACT_RD_W0: begin
            rd_addr = {sidx, pos_q_ff};
         end
         ACT_MIX: begin
            wr_en     = 1'b1;
            pos_wr_en = 1'b1;
         end
         ACT_MUL_LL: begin
            mul_en = 1'b1;
         end
         ACT_MUL_HL: begin
            mul_a  = new_ff[WORD_W-1:HALF_W];
            mul_en = 1'b1;
         end
         ACT_MUL_LH: begin
            mul_b  = OUT_MULT[WORD_W-1:HALF_W];
            mul_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_mem[wr_addr] <= wr_data;
      end
      word_q_ff <= words_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pos_wr_en) begin
         pos_mem[sidx] <= pos_wr_data;
      end
      pos_q_ff <= pos_mem[sidx];
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (ctl.act)
         ACT_IDLE: begin
            if (req_accept) begin
               stream_ff <= req_stream;
               x_ff      <= req_seed;
               lo_ff     <= req_seed;
               k_ff      <= FIRST_K;
            end
         end
         ACT_SEED_ADD: begin
            x_ff <= seed_next;
            k_ff <= k_ff + 1'b1;
            if (!k_ff[0]) begin
               lo_ff <= seed_next;
            end
         end
         ACT_RD_W0: begin
            p_ff <= pos_q_ff + 1'b1;
         end
         ACT_RD_W1: begin
            s0_ff <= word_q_ff ^ (word_q_ff >> 30);
         end
         ACT_MIX: begin
            new_ff <= mix_word;
         end
         ACT_MUL_HL: begin
            acc_ff <= prod_ff;
         end
         ACT_MUL_LH: begin
            acc_ff[WORD_W-1:HALF_W] <= acc_ff[WORD_W-1:HALF_W] + prod_ff[HALF_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= {acc_ff[WORD_W-1:HALF_W] + prod_ff[HALF_W-1:0], acc_ff[HALF_W-1:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   property p_emit_loads;
      @(posedge clock) disable iff (reset)
      emit |=> rsp_tvalid;
   endproperty
   a_emit_loads: assert property (p_emit_loads)
      else $error("result step did not load output");

   property p_seed_start;
      @(posedge clock) disable iff (reset)
      (req_accept && in_range && req_tuser == MODE_SEED) |=> (ctl.act == ACT_SEED_MUL);
   endproperty
   a_seed_start: assert property (p_seed_start)
      else $error("seed item did not start recurrence");

   property p_drop_stays_ready;
      @(posedge clock) disable iff (reset)
      (req_accept && !in_range) |=> req_tready;
   endproperty
   a_drop_stays_ready: assert property (p_drop_stays_ready)
      else $error("dropped item left idle");

   property p_seed_k_range;
      @(posedge clock) disable iff (reset)
      (ctl.act == ACT_SEED_MUL) |-> (k_ff != '0);
   endproperty
   a_seed_k_range: assert property (p_seed_k_range)
      else $error("recurrence step count out of range");

endmodule
`default_nettype wire

FILE: rtl/msx_seq.sv
// Sequencer: step counter over the control program with conditional jumps.
`default_nettype none
module msx_seq
   import msx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output ctl_type         ctl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;

   always_comb begin
      ctl = msx_rom(pc_ff);
   end

   always_comb begin
      pc_in = pc_ff;
      unique case (ctl.cond)
         COND_NEXT: begin
            pc_in = pc_ff + 1'b1;
         end
         COND_JUMP: begin
            pc_in = ctl.target;
         end
         COND_DISPATCH: begin
            if (status.accept && status.in_range) begin
               pc_in = status.seed ? pc_ff + 1'b1 : ctl.target;
            end
         end
         COND_LOOP_K: begin
            pc_in = status.k_last ? pc_ff + 1'b1 : ctl.target;
         end
         COND_WAIT_OUT: begin
            if (status.out_free) begin
               pc_in = ctl.target;
            end
         end
         default: begin
            pc_in = PC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   property p_seed_loop_stays;
      @(posedge clock) disable iff (reset)
      (ctl.act == ACT_SEED_ADD && !status.k_last) |=> (ctl.act == ACT_SEED_MUL);
   endproperty
   a_seed_loop_stays: assert property (p_seed_loop_stays)
      else $error("seed loop left early");

   property p_emit_hold;
      @(posedge clock) disable iff (reset)
      (ctl.act == ACT_EMIT && !status.out_free) |=> (ctl.act == ACT_EMIT);
   endproperty
   a_emit_hold: assert property (p_emit_hold)
      else $error("result step left while output full");

   property p_dispatch_draw;
      @(posedge clock) disable iff (reset)
      (ctl.act == ACT_IDLE && status.accept && status.in_range && !status.seed)
         |=> (ctl.act == ACT_RD_POS);
   endproperty
   a_dispatch_draw: assert property (p_dispatch_draw)
      else $error("draw not dispatched");

endmodule
`default_nettype wire

FILE: tb/multi_stream_xorshift1024_star_top_tb.sv
// Testbench for the multi-stream xorshift1024* block: scoreboard against a local generator model.
module multi_stream_xorshift1024_star_top_tb
   import msx_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSTREAMS     = 8;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 100;
   localparam int PRESSURE_AT  = 200;
   localparam int PRESSURE_LEN = 400;
   localparam logic [31:0] SEED_MULT = 32'd1812433253;
   localparam logic [63:0] STAR_MULT = 64'd1181783497276652981;

   typedef struct packed {
      logic        mode;
      logic [2:0]  stream;
      logic [31:0] seed;
   } req_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [2:0] stream, [34:3] seed_value, [39:35] zero
   logic                  req_tuser;   // [0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [63:0] random_word

   logic [63:0] gen_words [NSTREAMS][16];
   logic [3:0]  gen_pos [NSTREAMS];
   logic        gen_seeded [NSTREAMS];
   logic [63:0] pending_words [$];

   int unsigned error_count;
   int unsigned seeds_sent;
   int unsigned draws_sent;
   int unsigned words_checked;
   logic        calm;

   req_item_type directed_items [0:21] = '{
      '{MODE_SEED, 3'd0, 32'h0000_0000},
      '{MODE_SEED, 3'd7, 32'hFFFF_FFFF},
      '{MODE_DRAW, 3'd0, 32'h0000_0000},
      '{MODE_DRAW, 3'd7, 32'hFFFF_FFFF},
      '{MODE_DRAW, 3'd0, 32'h1234_5678},
      '{MODE_SEED, 3'd3, 32'h0000_0001},
      '{MODE_DRAW, 3'd3, 32'h0000_0000},
      '{MODE_SEED, 3'd0, 32'hDEAD_BEEF},
      '{MODE_DRAW, 3'd0, 32'h0000_0000},
      '{MODE_DRAW, 3'd0, 32'hFFFF_FFFF},
      '{MODE_SEED, 3'd5, 32'h8000_0000},
      '{MODE_SEED, 3'd5, 32'h7FFF_FFFF},
      '{MODE_DRAW, 3'd5, 32'h0000_0000},
      '{MODE_DRAW, 3'd7, 32'h0000_0000},
      '{MODE_SEED, 3'd1, 32'h5555_5555},
      '{MODE_SEED, 3'd2, 32'hAAAA_AAAA},
      '{MODE_SEED, 3'd4, 32'h1234_5678},
      '{MODE_SEED, 3'd6, 32'h0000_FFFF},
      '{MODE_DRAW, 3'd1, 32'h0000_0000},
      '{MODE_DRAW, 3'd2, 32'h0000_0000},
      '{MODE_DRAW, 3'd4, 32'h0000_0000},
      '{MODE_DRAW, 3'd6, 32'h0000_0000}
   };

   multi_stream_xorshift1024_star_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [31:0] warm_step(input logic [31:0] x, input logic [31:0] k);
      logic [31:0] r;
      r = SEED_MULT * (x ^ (x >> 30)) + k;
      return r;
   endfunction

   function automatic void seed_generator(input logic [2:0] s, input logic [31:0] seed);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = seed;
      hi = warm_step(lo, 32'd1);
      gen_words[s][0] = {hi, lo};
      for (int j = 1; j < 16; j++) begin
         lo = warm_step(hi, 2 * j);
         hi = warm_step(lo, 2 * j + 1);
         gen_words[s][j] = {hi, lo};
      end
      gen_pos[s] = 4'd15;
      gen_seeded[s] = 1'b1;
   endfunction

   function automatic logic [63:0] next_random_word(input logic [2:0] s);
      logic [3:0]  p;
      logic [63:0] s0;
      logic [63:0] s1;
      logic [63:0] prod;
      p  = gen_pos[s];
      s0 = gen_words[s][p];
      p  = p + 4'd1;
      s1 = gen_words[s][p];
      s1 = s1 ^ (s1 << 31);
      s1 = s1 ^ (s1 >> 11);
      s0 = s0 ^ (s0 >> 30);
      gen_words[s][p] = s0 ^ s1;
      gen_pos[s] = p;
      prod = gen_words[s][p] * STAR_MULT;
      return prod;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // hold the word until taken, then update the generator model
   task automatic send_item(input req_item_type item);
      int unsigned gap;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = item.mode;
      req_tdata  = {5'b0, item.seed, item.stream};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (item.mode == MODE_SEED) begin
         seed_generator(item.stream, item.seed);
         seeds_sent++;
      end else begin
         pending_words.push_back(next_random_word(item.stream));
         draws_sent++;
      end
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected random_word, expected none, got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: random_word mismatch, expected %h, got %h",
                        $time, want, rsp_tdata);
               error_count++;
            end
         end
         words_checked++;
      end
   end

   initial begin
      int unsigned hold;
      logic        pressed;
      hold = 0;
      pressed = 1'b0;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (!pressed && words_checked >= PRESSURE_AT) begin
            pressed = 1'b1;
            hold = PRESSURE_LEN;
         end
         if (hold != 0) hold--;
         else if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
         rsp_tready = (hold == 0);
         @(negedge clock);
      end
   end

   initial begin
      #10ms;
      $display("multi_stream_xorshift1024_star_top_tb: done, errors");
      $finish;
   end

   initial begin
      req_item_type item;
      int unsigned  r;
      error_count   = 0;
      seeds_sent    = 0;
      draws_sent    = 0;
      words_checked = 0;
      calm          = 1'b0;
      for (int s = 0; s < NSTREAMS; s++) begin
         gen_pos[s] = 4'd0;
         gen_seeded[s] = 1'b0;
      end
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_DRAW;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 22; i++) send_item(directed_items[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 300 && i < 400);
         item.stream = 3'($urandom_range(0, NSTREAMS - 1));
         r = $urandom_range(0, 19);
         if (r < 3 || !gen_seeded[item.stream]) begin
            item.mode = MODE_SEED;
            r = $urandom_range(0, 9);
            if (r == 0) item.seed = 32'h0000_0000;
            else if (r == 1) item.seed = 32'hFFFF_FFFF;
            else item.seed = $urandom;
         end else begin
            item.mode = MODE_DRAW;
            item.seed = $urandom;
         end
         send_item(item);
      end
      req_tvalid = 1'b0;
      calm = 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d seeds and %0d draws on %0d streams, %0d words checked",
               seeds_sent, draws_sent, NSTREAMS, words_checked);
      $display("included a long output stall of %0d cycles with input backpressure",
               PRESSURE_LEN);
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("multi_stream_xorshift1024_star_top_tb: done, clean");
      end else begin
         $display("multi_stream_xorshift1024_star_top_tb: done, errors");
      end
      $finish;
   end

endmodule
